/* hdl/feqt_pkg.sv */
// Package for the flow event queue table: request and status codes, default sizes,
// and the command and status structs between controller and datapath.
// No dependencies.
package feqt_pkg;

  localparam int NUM_FLOWS_DEF   = 256;
  localparam int NUM_QUEUES_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 64;

  localparam logic [2:0] REQ_ADD    = 3'd0;
  localparam logic [2:0] REQ_DEL    = 3'd1;
  localparam logic [2:0] REQ_HAS    = 3'd2;
  localparam logic [2:0] REQ_ZERO   = 3'd3;
  localparam logic [2:0] REQ_NOTIFY = 3'd4;
  localparam logic [2:0] REQ_DRAIN  = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MAPPED   = 3'd1;
  localparam logic [2:0] ST_UNMAPPED = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic exec;
    logic zero_start;
    logic zero_step;
    logic zero_fin;
    logic drain_start;
    logic drain_rd;
    logic drain_out;
  } feqt_cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       q_ok;
    logic       drain_empty;
    logic       clear_done;
    logic       sweep_done;
    logic       drain_last;
    logic       out_free;
  } feqt_stat_t;

endpackage

/* hdl/feqt_ram.sv */
// Generic simple dual-port RAM: one write port and one registered read port.
// No dependencies.
module feqt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/feqt_datapath.sv */
// Datapath of the flow event queue table: request register, flow map and event store
// RAMs, per-queue fill counts, sweep and drain counters, and the output register.
// Depends on feqt_pkg and feqt_ram.
module feqt_datapath #(
  parameter int NUM_FLOWS   = feqt_pkg::NUM_FLOWS_DEF,
  parameter int NUM_QUEUES  = feqt_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = feqt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  feqt_pkg::feqt_cmd_t   cmd,
  output feqt_pkg::feqt_stat_t  stat,
  input  logic [2:0]            in_req_type,
  input  logic [7:0]            in_flow_id,
  input  logic [2:0]            in_queue_index,
  input  logic [15:0]           in_event_req,
  output logic                  m_valid,
  input  logic                  m_ready,
  output logic [2:0]            m_status,
  output logic                  m_is_member,
  output logic [7:0]            m_out_flow,
  output logic [15:0]           m_out_event,
  output logic [6:0]            m_drained_count,
  output logic                  m_last
);

  localparam int FLOW_AW = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
  localparam int Q_AW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int D_AW    = $clog2(QUEUE_DEPTH);
  localparam int FW      = $clog2(QUEUE_DEPTH + 1);
  localparam int CW      = $clog2(NUM_FLOWS + 1);
  localparam int MAP_W   = Q_AW + 1;
  localparam int ST_AW   = Q_AW + D_AW;

  logic [2:0]  req_type;
  logic [7:0]  req_flow;
  logic [2:0]  req_queue;
  logic [15:0] req_event;

  logic [CW-1:0] cnt;
  logic [FW-1:0] fill [NUM_QUEUES];
  logic [FW-1:0] drain_idx;
  logic [FW-1:0] drain_n;

  logic               map_wr_en;
  logic [FLOW_AW-1:0] map_wr_addr;
  logic [MAP_W-1:0]   map_wr_data;
  logic               map_rd_en;
  logic [FLOW_AW-1:0] map_rd_addr;
  logic [MAP_W-1:0]   map_rd_data;

  logic             st_wr_en;
  logic [ST_AW-1:0] st_wr_addr;
  logic [23:0]      st_wr_data;
  logic [ST_AW-1:0] st_rd_addr;
  logic [23:0]      st_rd_data;

  logic            entry_valid;
  logic [Q_AW-1:0] entry_q;
  logic [Q_AW-1:0] req_q;
  logic            flow_ok;
  logic            q_ok;
  logic            member;
  logic [Q_AW-1:0] fill_sel;
  logic [FW-1:0]   fill_cur;
  logic            queue_full;
  logic            notify_ok;
  logic            add_ok;
  logic            zero_hit;
  logic            drain_last;
  logic [2:0]      exec_status;
  logic            out_load;

  assign entry_valid = map_rd_data[MAP_W-1];
  assign entry_q     = map_rd_data[Q_AW-1:0];
  assign req_q       = Q_AW'(req_queue);
  assign flow_ok     = {24'd0, req_flow} < 32'(NUM_FLOWS);
  assign q_ok        = {29'd0, req_queue} < 32'(NUM_QUEUES);
  assign member      = flow_ok & q_ok & entry_valid & (entry_q == req_q);
  assign fill_sel    = (req_type == feqt_pkg::REQ_NOTIFY) ? entry_q : req_q;
  assign fill_cur    = fill[fill_sel];
  assign queue_full  = fill_cur >= FW'(QUEUE_DEPTH);
  assign notify_ok   = flow_ok & entry_valid & ~queue_full;
  assign add_ok      = flow_ok & q_ok & ~entry_valid;
  assign zero_hit    = entry_valid & (entry_q == req_q);
  assign drain_last  = drain_idx == (drain_n - FW'(1));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_type  <= in_req_type;
      req_flow  <= in_flow_id;
      req_queue <= in_queue_index;
      req_event <= in_event_req;
    end
  end

  always_comb begin
    map_rd_en   = cmd.accept | (cmd.zero_step & (cnt < CW'(NUM_FLOWS)));
    map_rd_addr = cmd.accept ? FLOW_AW'(in_flow_id) : FLOW_AW'(cnt);
    map_wr_en   = 1'b0;
    map_wr_addr = FLOW_AW'(req_flow);
    map_wr_data = '0;
    if (cmd.clr_step) begin
      map_wr_en   = 1'b1;
      map_wr_addr = FLOW_AW'(cnt);
    end else if (cmd.zero_step) begin
      map_wr_en   = (cnt != '0) & zero_hit;
      map_wr_addr = FLOW_AW'(cnt - CW'(1));
    end else if (cmd.exec) begin
      if (req_type == feqt_pkg::REQ_ADD) begin
        map_wr_en   = add_ok;
        map_wr_data = {1'b1, req_q};
      end else if (req_type == feqt_pkg::REQ_DEL) begin
        map_wr_en   = member;
      end
    end
  end

  assign st_wr_en   = cmd.exec & (req_type == feqt_pkg::REQ_NOTIFY) & notify_ok;
  assign st_wr_addr = {entry_q, D_AW'(fill_cur)};
  assign st_wr_data = {req_flow, req_event};
  assign st_rd_addr = {req_q, D_AW'(drain_idx)};

  feqt_ram #(
    .WIDTH(MAP_W),
    .DEPTH(NUM_FLOWS)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (map_wr_en),
    .wr_addr (map_wr_addr),
    .wr_data (map_wr_data),
    .rd_en   (map_rd_en),
    .rd_addr (map_rd_addr),
    .rd_data (map_rd_data)
  );

  feqt_ram #(
    .WIDTH(24),
    .DEPTH(1 << ST_AW)
  ) u_store_ram (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (cmd.drain_rd),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.zero_start) begin
      cnt <= '0;
    end else if (cmd.clr_step || cmd.zero_step) begin
      cnt <= cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        fill[i] <= '0;
      end
    end else if (st_wr_en) begin
      fill[entry_q] <= fill_cur + FW'(1);
    end else if (cmd.zero_fin || (cmd.drain_out && drain_last)) begin
      fill[req_q] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain_start) begin
      drain_idx <= '0;
      drain_n   <= fill_cur;
    end else if (cmd.drain_out) begin
      drain_idx <= drain_idx + FW'(1);
    end
  end

  always_comb begin
    case (req_type)
      feqt_pkg::REQ_ADD: begin
        if (!flow_ok || !q_ok) begin
          exec_status = feqt_pkg::ST_UNMAPPED;
        end else if (entry_valid) begin
          exec_status = feqt_pkg::ST_MAPPED;
        end else begin
          exec_status = feqt_pkg::ST_OK;
        end
      end
      feqt_pkg::REQ_NOTIFY: begin
        if (!flow_ok || !entry_valid) begin
          exec_status = feqt_pkg::ST_UNMAPPED;
        end else if (queue_full) begin
          exec_status = feqt_pkg::ST_FULL;
        end else begin
          exec_status = feqt_pkg::ST_OK;
        end
      end
      feqt_pkg::REQ_DRAIN: exec_status = feqt_pkg::ST_EMPTY;
      default:             exec_status = feqt_pkg::ST_OK;
    endcase
  end

  assign out_load = cmd.exec | cmd.zero_fin | cmd.drain_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= out_load | (m_valid & ~m_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_status        <= cmd.exec ? exec_status : feqt_pkg::ST_OK;
      m_is_member     <= cmd.exec & (req_type == feqt_pkg::REQ_HAS) & member;
      m_out_flow      <= cmd.drain_out ? st_rd_data[23:16] : 8'd0;
      m_out_event     <= cmd.drain_out ? st_rd_data[15:0] : 16'd0;
      m_drained_count <= cmd.drain_out ? 7'(drain_n) : 7'd0;
      m_last          <= ~cmd.drain_out | drain_last;
    end
  end

  assign stat.req_type    = req_type;
  assign stat.q_ok        = q_ok;
  assign stat.drain_empty = ~q_ok | (fill_cur == '0);
  assign stat.clear_done  = cnt == CW'(NUM_FLOWS - 1);
  assign stat.sweep_done  = cnt == CW'(NUM_FLOWS);
  assign stat.drain_last  = drain_last;
  assign stat.out_free    = ~m_valid | m_ready;

endmodule

/* hdl/feqt_ctrl.sv */
// Controller of the flow event queue table: sequences the reset clearing pass,
// single-step requests, the zero sweep and the drain loop.
// Depends on feqt_pkg.
module feqt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_valid,
  output logic                 s_ready,
  input  feqt_pkg::feqt_stat_t stat,
  output feqt_pkg::feqt_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_EXEC   = 7'b0000100,
    S_ZSWEEP = 7'b0001000,
    S_ZFIN   = 7'b0010000,
    S_DRD    = 7'b0100000,
    S_DOUT   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign s_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.req_type == feqt_pkg::REQ_ZERO && stat.q_ok) begin
          cmd.zero_start = 1'b1;
          state_next     = S_ZSWEEP;
        end else if (stat.req_type == feqt_pkg::REQ_DRAIN && !stat.drain_empty) begin
          cmd.drain_start = 1'b1;
          state_next      = S_DRD;
        end else if (stat.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ZSWEEP: begin
        cmd.zero_step = 1'b1;
        if (stat.sweep_done) begin
          state_next = S_ZFIN;
        end
      end
      S_ZFIN: begin
        if (stat.out_free) begin
          cmd.zero_fin = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DRD: begin
        cmd.drain_rd = 1'b1;
        state_next   = S_DOUT;
      end
      S_DOUT: begin
        if (stat.out_free) begin
          cmd.drain_out = 1'b1;
          state_next    = stat.drain_last ? S_IDLE : S_DRD;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

/* hdl/flow_event_queue_table.sv */
// Top level of the flow event queue table: stream ports, controller and datapath.
// Depends on feqt_pkg, feqt_ctrl and feqt_datapath.
//
// Requests enter on the s_axis channel, one transaction per request; the request
// type travels in s_axis_tuser. Results leave on the m_axis channel; every request
// gives one result transaction, except a drain of a non-empty queue, which gives
// one per stored event in arrival order, with m_axis_tlast on the final one.
// Add, del, has and notify register the request together with the flow map read,
// then make the update and load the result; a new request is taken only after the
// result of the previous one is loaded. Zero of a valid queue walks the whole flow
// map. A drain delivers one event at a time, each fetched through the registered
// read of the event store before it is output.
// After reset the flow map is cleared in a pass over all NUM_FLOWS entries, during
// which s_axis_tready stays low; fill counts are cleared at once.
// Results sit in an output register; while the receiver stalls, the block takes at
// most one more request and then holds before loading its result.
module flow_event_queue_table #(
  parameter int NUM_FLOWS   = feqt_pkg::NUM_FLOWS_DEF,
  parameter int NUM_QUEUES  = feqt_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = feqt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // flow_id [7:0], queue_index [10:8], event_req [26:11], zero [31:27]
  input  logic [31:0] s_axis_tdata,
  // req_type [2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // is_member [0], out_flow [8:1], out_event [24:9], drained_count [31:25]
  output logic [31:0] m_axis_tdata,
  // status [2:0]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  feqt_pkg::feqt_cmd_t  cmd;
  feqt_pkg::feqt_stat_t stat;

  feqt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  feqt_datapath #(
    .NUM_FLOWS   (NUM_FLOWS),
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_req_type     (s_axis_tuser),
    .in_flow_id      (s_axis_tdata[7:0]),
    .in_queue_index  (s_axis_tdata[10:8]),
    .in_event_req    (s_axis_tdata[26:11]),
    .m_valid         (m_axis_tvalid),
    .m_ready         (m_axis_tready),
    .m_status        (m_axis_tuser),
    .m_is_member     (m_axis_tdata[0]),
    .m_out_flow      (m_axis_tdata[8:1]),
    .m_out_event     (m_axis_tdata[24:9]),
    .m_drained_count (m_axis_tdata[31:25]),
    .m_last          (m_axis_tlast)
  );

endmodule

/* hdl/feqt_checker.sv */
// Port-level checks for the flow event queue table, bound to the top level.
// Depends on feqt_pkg and flow_event_queue_table.
module feqt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is in progress");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !s_axis_tready)
    else $error("request taken before the flow map clear");

  a_non_last_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == feqt_pkg::ST_OK)
    else $error("non-final result carries an error status");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != feqt_pkg::ST_OK |->
      m_axis_tlast && m_axis_tdata == 32'd0)
    else $error("error result is not a clean single transaction");

endmodule

bind flow_event_queue_table feqt_checker u_feqt_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
